[rtl/c8x_pkg.sv]
// ============================================================================
// c8x_pkg
// Shared types, constants and tables for the CHIP-8 execute core.
// ============================================================================
package c8x_pkg;

    // default sizes
    localparam int MEM_DEPTH_DEF     = 4096;
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int START_ADDRESS_DEF = 512;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_STUB    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_BOUND   = 3'd3;
    localparam logic [2:0] ST_NOMATCH = 3'd4;

    // opcode groups (top nibble)
    localparam logic [3:0] OPG_SYS    = 4'h0;
    localparam logic [3:0] OPG_JUMP   = 4'h1;
    localparam logic [3:0] OPG_CALL   = 4'h2;
    localparam logic [3:0] OPG_SKEQ   = 4'h3;
    localparam logic [3:0] OPG_SKNE   = 4'h4;
    localparam logic [3:0] OPG_SKREQ  = 4'h5;
    localparam logic [3:0] OPG_LDIMM  = 4'h6;
    localparam logic [3:0] OPG_ADDIMM = 4'h7;
    localparam logic [3:0] OPG_ALU    = 4'h8;
    localparam logic [3:0] OPG_SKRNE  = 4'h9;
    localparam logic [3:0] OPG_LDIDX  = 4'hA;
    localparam logic [3:0] OPG_JUMPV0 = 4'hB;
    localparam logic [3:0] OPG_RAND   = 4'hC;
    localparam logic [3:0] OPG_DRAW   = 4'hD;
    localparam logic [3:0] OPG_KEY    = 4'hE;
    localparam logic [3:0] OPG_MISC   = 4'hF;

    localparam logic [15:0] OP_RET = 16'h00EE;

    // alu sub-codes (low nibble of 8XYN)
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // key group codes
    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    // misc group codes (low byte of FXNN)
    localparam logic [7:0] FN_DT_GET  = 8'h07;
    localparam logic [7:0] FN_KEY_WT  = 8'h0A;
    localparam logic [7:0] FN_DT_SET  = 8'h15;
    localparam logic [7:0] FN_ST_SET  = 8'h18;
    localparam logic [7:0] FN_IDX_ADD = 8'h1E;
    localparam logic [7:0] FN_FONT    = 8'h29;
    localparam logic [7:0] FN_BCD     = 8'h33;
    localparam logic [7:0] FN_DUMP    = 8'h55;
    localparam logic [7:0] FN_LOAD    = 8'h65;

    localparam logic [3:0] FLAG_REG  = 4'hF;
    localparam int         FONT_SIZE = 80;
    localparam logic [7:0] FILL_BYTE = 8'h12;

    // hex font, five bytes per glyph
    localparam logic [7:0] FONT_GLYPHS [FONT_SIZE] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // follow-up work an opcode needs after its execute cycle
    typedef enum logic [1:0] {
        CL_PLAIN,
        CL_FLAG,
        CL_BCD,
        CL_XFER
    } op_class_t;

    // controller to datapath
    typedef struct packed {
        logic       clr;
        logic       latch;
        logic       rd_first;
        logic       rd_y;
        logic       cap_vx;
        logic       cap_vy;
        logic       exec;
        logic       flag_wr;
        logic       bcd_wr;
        logic [1:0] bcd_sel;
        logic       x_rd;
        logic       x_wr;
        logic       fix;
        logic       wb_x;
        logic       wb_f;
        logic       out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_class_t cls;
        logic      is_load;
        logic      clr_done;
        logic      pc_over;
        logic      x_oob;
        logic      x_last;
    } dp_sts_t;

endpackage

[rtl/c8x_ctrl.sv]
// ============================================================================
// c8x_ctrl
// Sequencer for the execute core: walks each word through operand reads,
// execute, follow-up flag or memory work, pc wrap and result capture.
// ============================================================================
module c8x_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              m_ready,
    input  c8x_pkg::dp_sts_t  sts,
    output logic              s_ready,
    output logic              m_valid,
    output c8x_pkg::dp_cmd_t  cmd
);

    typedef enum logic [15:0] {
        S_CLEAR = 16'h0001,
        S_IDLE  = 16'h0002,
        S_RDX   = 16'h0004,
        S_RDY   = 16'h0008,
        S_RDW   = 16'h0010,
        S_EXEC  = 16'h0020,
        S_FLAG  = 16'h0040,
        S_BCD0  = 16'h0080,
        S_BCD1  = 16'h0100,
        S_BCD2  = 16'h0200,
        S_XRD   = 16'h0400,
        S_XWR   = 16'h0800,
        S_FIX   = 16'h1000,
        S_WBX   = 16'h2000,
        S_WBF   = 16'h4000,
        S_DONE  = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_RDX;
                end
            end
            S_RDX: begin
                if (sts.is_load) begin
                    state_next = S_EXEC;
                end else begin
                    cmd.rd_first = 1'b1;
                    state_next   = S_RDY;
                end
            end
            S_RDY: begin
                cmd.cap_vx = 1'b1;
                cmd.rd_y   = 1'b1;
                state_next = S_RDW;
            end
            S_RDW: begin
                cmd.cap_vy = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                case (sts.cls)
                    c8x_pkg::CL_FLAG: state_next = S_FLAG;
                    c8x_pkg::CL_BCD:  state_next = S_BCD0;
                    c8x_pkg::CL_XFER: state_next = S_XRD;
                    default:          state_next = S_FIX;
                endcase
            end
            S_FLAG: begin
                cmd.flag_wr = 1'b1;
                state_next  = S_FIX;
            end
            S_BCD0: begin
                cmd.bcd_wr  = 1'b1;
                cmd.bcd_sel = 2'd0;
                state_next  = S_BCD1;
            end
            S_BCD1: begin
                cmd.bcd_wr  = 1'b1;
                cmd.bcd_sel = 2'd1;
                state_next  = S_BCD2;
            end
            S_BCD2: begin
                cmd.bcd_wr  = 1'b1;
                cmd.bcd_sel = 2'd2;
                state_next  = S_FIX;
            end
            S_XRD: begin
                cmd.x_rd   = 1'b1;
                state_next = sts.x_oob ? S_FIX : S_XWR;
            end
            S_XWR: begin
                cmd.x_wr   = 1'b1;
                state_next = sts.x_last ? S_FIX : S_XRD;
            end
            S_FIX: begin
                cmd.fix = 1'b1;
                if (!sts.pc_over) state_next = S_WBX;
            end
            S_WBX: begin
                cmd.wb_x   = 1'b1;
                state_next = S_WBF;
            end
            S_WBF: begin
                cmd.wb_f   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // output word valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[rtl/c8x_datapath.sv]
// ============================================================================
// c8x_datapath
// Register file, index, pc, return stack, main memory and the execute logic
// of the CHIP-8 core, driven step by step by the controller.
// ============================================================================
module c8x_datapath #(
    parameter int MEM_DEPTH     = c8x_pkg::MEM_DEPTH_DEF,
    parameter int STACK_DEPTH   = c8x_pkg::STACK_DEPTH_DEF,
    parameter int START_ADDRESS = c8x_pkg::START_ADDRESS_DEF,
    localparam int CW           = $clog2(STACK_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  c8x_pkg::dp_cmd_t  cmd,
    output c8x_pkg::dp_sts_t  sts,
    input  logic              s_kind,
    input  logic [15:0]       s_opcode,
    input  logic [7:0]        s_random_byte,
    input  logic [11:0]       s_load_address,
    input  logic [7:0]        s_load_data,
    output logic [11:0]       m_program_counter,
    output logic [11:0]       m_index_value,
    output logic [7:0]        m_flag_value,
    output logic [7:0]        m_dest_value,
    output logic [CW-1:0]     m_stack_depth,
    output logic [2:0]        m_status
);

    localparam int          AW        = $clog2(MEM_DEPTH);
    localparam int          SW        = $clog2(STACK_DEPTH);
    localparam logic [12:0] MEM_LIM   = 13'(MEM_DEPTH);
    localparam logic [12:0] START_LIM = 13'(START_ADDRESS);
    localparam logic [12:0] PC_RESET  = 13'(START_ADDRESS % MEM_DEPTH);
    localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_DEPTH - 1);

    // storage
    logic [7:0]  mem [MEM_DEPTH];
    logic [7:0]  rf [16];
    logic [11:0] stk [STACK_DEPTH];

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata_reg;
    logic          rf_we, rf_re;
    logic [3:0]    rf_waddr, rf_raddr;
    logic [7:0]    rf_wdata, rf_rdata_reg;
    logic          stk_we, stk_re;
    logic [SW-1:0] stk_waddr, stk_raddr;
    logic [11:0]   stk_rdata_reg;

    // item and machine registers
    logic          kind_reg;
    logic [15:0]   op_reg;
    logic [7:0]    rnd_reg, ld_reg;
    logic [11:0]   la_reg;
    logic [12:0]   pc_reg, pc_next;
    logic [11:0]   idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    st_reg, st_next;
    logic [7:0]    vx_reg, vx_next, vy_reg, vy_next, dest_reg, dest_next;
    logic          flag_reg, flag_next;
    logic [3:0]    k_reg, k_next;
    logic [AW-1:0] clr_reg, clr_next;

    // opcode fields and helpers
    logic [3:0]  op_x, op_y, op_n, op_grp;
    logic [7:0]  op_nn;
    logic [11:0] op_nnn;
    logic [12:0] pc_inc2, pc_inc4, x_addr, bcd_top, bcd_addr;
    logic [CW-1:0] cnt_dec;
    logic        bcd_oob, is_dump;
    logic [8:0]  add_sum;
    logic [7:0]  clr_byte;

    assign op_grp  = op_reg[15:12];
    assign op_x    = op_reg[11:8];
    assign op_y    = op_reg[7:4];
    assign op_n    = op_reg[3:0];
    assign op_nn   = op_reg[7:0];
    assign op_nnn  = op_reg[11:0];
    assign pc_inc2 = pc_reg + 13'd2;
    assign pc_inc4 = pc_reg + 13'd4;
    assign x_addr  = {1'b0, idx_reg} + {9'd0, k_reg};
    assign bcd_top = {1'b0, idx_reg} + 13'd2;
    assign bcd_oob = (bcd_top >= MEM_LIM);
    assign bcd_addr = {1'b0, idx_reg} + {11'd0, cmd.bcd_sel};
    assign cnt_dec = cnt_reg - CW'(1);
    assign is_dump = (op_nn == c8x_pkg::FN_DUMP);
    assign add_sum = {1'b0, vx_reg} + {1'b0, vy_reg};

    // bcd digits: hundreds by compare, tens by reciprocal multiply
    logic [1:0]  bcd_h;
    logic [7:0]  bcd_r8;
    logic [6:0]  bcd_r;
    logic [14:0] bcd_prod;
    logic [3:0]  bcd_t, bcd_o;
    logic [6:0]  bcd_t10;
    logic [7:0]  bcd_digit;

    always_comb begin
        if (vx_reg >= 8'd200) begin
            bcd_h  = 2'd2;
            bcd_r8 = vx_reg - 8'd200;
        end else if (vx_reg >= 8'd100) begin
            bcd_h  = 2'd1;
            bcd_r8 = vx_reg - 8'd100;
        end else begin
            bcd_h  = 2'd0;
            bcd_r8 = vx_reg;
        end
        bcd_r    = bcd_r8[6:0];
        bcd_prod = {8'd0, bcd_r} * 15'd205;
        bcd_t    = bcd_prod[14:11];
        bcd_t10  = {bcd_t, 3'b000} + {2'b00, bcd_t, 1'b0};
        bcd_o    = 4'(bcd_r - bcd_t10);
        case (cmd.bcd_sel)
            2'd0:    bcd_digit = {6'd0, bcd_h};
            2'd1:    bcd_digit = {4'd0, bcd_t};
            default: bcd_digit = {4'd0, bcd_o};
        endcase
    end

    // power-up memory image
    always_comb begin
        if ({{(13 - AW){1'b0}}, clr_reg} < 13'(c8x_pkg::FONT_SIZE)) begin
            clr_byte = c8x_pkg::FONT_GLYPHS[clr_reg[6:0]];
        end else if ({{(13 - AW){1'b0}}, clr_reg} < START_LIM) begin
            clr_byte = clr_reg[0] ? 8'h00 : c8x_pkg::FILL_BYTE;
        end else begin
            clr_byte = 8'h00;
        end
    end

    // follow-up class of the current opcode
    always_comb begin
        sts.cls = c8x_pkg::CL_PLAIN;
        if (!kind_reg) begin
            if (op_grp == c8x_pkg::OPG_ALU) begin
                if (op_n inside {c8x_pkg::ALU_ADD, c8x_pkg::ALU_SUB,
                                 c8x_pkg::ALU_SHR, c8x_pkg::ALU_SHL}) begin
                    sts.cls = c8x_pkg::CL_FLAG;
                end
            end else if (op_grp == c8x_pkg::OPG_MISC) begin
                if (op_nn == c8x_pkg::FN_BCD && !bcd_oob) begin
                    sts.cls = c8x_pkg::CL_BCD;
                end else if (op_nn == c8x_pkg::FN_DUMP || op_nn == c8x_pkg::FN_LOAD) begin
                    sts.cls = c8x_pkg::CL_XFER;
                end
            end
        end
    end

    assign sts.is_load  = kind_reg;
    assign sts.clr_done = (clr_reg == CLR_LAST);
    assign sts.pc_over  = (pc_reg >= MEM_LIM);
    assign sts.x_oob    = (x_addr >= MEM_LIM);
    assign sts.x_last   = (k_reg == op_x);

    // main step logic
    always_comb begin
        pc_next   = pc_reg;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        st_next   = st_reg;
        vx_next   = vx_reg;
        vy_next   = vy_reg;
        dest_next = dest_reg;
        flag_next = flag_reg;
        k_next    = k_reg;
        clr_next  = clr_reg;
        mem_we    = 1'b0;
        mem_waddr = x_addr[AW-1:0];
        mem_wdata = rf_rdata_reg;
        mem_re    = 1'b0;
        mem_raddr = x_addr[AW-1:0];
        rf_we     = 1'b0;
        rf_waddr  = op_x;
        rf_wdata  = op_nn;
        rf_re     = 1'b0;
        rf_raddr  = op_x;
        stk_we    = 1'b0;
        stk_waddr = cnt_reg[SW-1:0];
        stk_re    = 1'b0;
        stk_raddr = cnt_dec[SW-1:0];

        // power-up sweep over memory, register file on the way
        if (cmd.clr) begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = clr_byte;
            rf_we     = (clr_reg[AW-1:4] == '0);
            rf_waddr  = clr_reg[3:0];
            rf_wdata  = 8'h00;
            clr_next  = clr_reg + AW'(1);
        end

        if (cmd.latch) k_next = 4'd0;

        // operand reads
        if (cmd.rd_first) begin
            rf_re    = 1'b1;
            rf_raddr = (op_grp == c8x_pkg::OPG_JUMPV0) ? 4'h0 : op_x;
            stk_re   = 1'b1;
        end
        if (cmd.cap_vx) vx_next = rf_rdata_reg;
        if (cmd.rd_y) begin
            rf_re    = 1'b1;
            rf_raddr = op_y;
        end
        if (cmd.cap_vy) vy_next = rf_rdata_reg;

        // execute
        if (cmd.exec) begin
            st_next = c8x_pkg::ST_OK;
            if (kind_reg) begin
                if ({1'b0, la_reg} < MEM_LIM) begin
                    mem_we    = 1'b1;
                    mem_waddr = la_reg[AW-1:0];
                    mem_wdata = ld_reg;
                end else begin
                    st_next = c8x_pkg::ST_BOUND;
                end
            end else begin
                pc_next = pc_inc2;
                case (op_grp)
                    c8x_pkg::OPG_SYS: begin
                        if (op_reg == c8x_pkg::OP_RET) begin
                            if (cnt_reg != '0) begin
                                cnt_next = cnt_dec;
                                pc_next  = {1'b0, stk_rdata_reg} + 13'd2;
                            end
                        end else begin
                            st_next = c8x_pkg::ST_STUB;
                        end
                    end
                    c8x_pkg::OPG_JUMP: pc_next = {1'b0, op_nnn};
                    c8x_pkg::OPG_CALL: begin
                        if (cnt_reg >= CNT_FULL) begin
                            st_next = c8x_pkg::ST_FULL;
                        end else begin
                            stk_we   = 1'b1;
                            cnt_next = cnt_reg + CW'(1);
                            pc_next  = {1'b0, op_nnn};
                        end
                    end
                    c8x_pkg::OPG_SKEQ: if (vx_reg == op_nn) pc_next = pc_inc4;
                    c8x_pkg::OPG_SKNE: if (vx_reg != op_nn) pc_next = pc_inc4;
                    c8x_pkg::OPG_SKREQ, c8x_pkg::OPG_SKRNE: begin
                        if (op_n != 4'h0) begin
                            st_next = c8x_pkg::ST_NOMATCH;
                            pc_next = pc_reg;
                        end else if ((vx_reg == vy_reg) ==
                                     (op_grp == c8x_pkg::OPG_SKREQ)) begin
                            pc_next = pc_inc4;
                        end
                    end
                    c8x_pkg::OPG_LDIMM: rf_we = 1'b1;
                    c8x_pkg::OPG_ADDIMM: begin
                        rf_we    = 1'b1;
                        rf_wdata = vx_reg + op_nn;
                    end
                    c8x_pkg::OPG_ALU: begin
                        rf_we = 1'b1;
                        case (op_n)
                            c8x_pkg::ALU_MOV: rf_wdata = vy_reg;
                            c8x_pkg::ALU_OR:  rf_wdata = vx_reg | vy_reg;
                            c8x_pkg::ALU_AND: rf_wdata = vx_reg & vy_reg;
                            c8x_pkg::ALU_XOR: rf_wdata = vx_reg ^ vy_reg;
                            c8x_pkg::ALU_ADD: begin
                                rf_wdata  = add_sum[7:0];
                                flag_next = add_sum[8];
                            end
                            c8x_pkg::ALU_SUB: begin
                                rf_wdata  = vx_reg - vy_reg;
                                flag_next = (vx_reg >= vy_reg);
                            end
                            c8x_pkg::ALU_SHR: begin
                                rf_wdata  = {1'b0, vy_reg[7:1]};
                                flag_next = vy_reg[0];
                            end
                            c8x_pkg::ALU_SHL: begin
                                rf_wdata  = {vy_reg[6:0], 1'b0};
                                flag_next = vy_reg[7];
                            end
                            c8x_pkg::ALU_SUBN: begin
                                rf_we   = 1'b0;
                                st_next = c8x_pkg::ST_STUB;
                            end
                            default: begin
                                rf_we   = 1'b0;
                                st_next = c8x_pkg::ST_NOMATCH;
                                pc_next = pc_reg;
                            end
                        endcase
                    end
                    c8x_pkg::OPG_LDIDX:  idx_next = op_nnn;
                    c8x_pkg::OPG_JUMPV0: pc_next = {5'd0, vx_reg} + {1'b0, op_nnn};
                    c8x_pkg::OPG_RAND: begin
                        rf_we    = 1'b1;
                        rf_wdata = rnd_reg & op_nn;
                    end
                    c8x_pkg::OPG_DRAW: st_next = c8x_pkg::ST_STUB;
                    c8x_pkg::OPG_KEY: begin
                        if (op_nn == c8x_pkg::KEY_SKP || op_nn == c8x_pkg::KEY_SKNP) begin
                            st_next = c8x_pkg::ST_STUB;
                        end else begin
                            st_next = c8x_pkg::ST_NOMATCH;
                            pc_next = pc_reg;
                        end
                    end
                    default: begin
                        case (op_nn)
                            c8x_pkg::FN_DT_GET, c8x_pkg::FN_KEY_WT,
                            c8x_pkg::FN_DT_SET, c8x_pkg::FN_ST_SET:
                                st_next = c8x_pkg::ST_STUB;
                            c8x_pkg::FN_IDX_ADD: idx_next = idx_reg + {4'd0, vx_reg};
                            c8x_pkg::FN_FONT:
                                idx_next = {6'd0, vx_reg[3:0], 2'b00} + {8'd0, vx_reg[3:0]};
                            c8x_pkg::FN_BCD: if (bcd_oob) st_next = c8x_pkg::ST_BOUND;
                            c8x_pkg::FN_DUMP, c8x_pkg::FN_LOAD: st_next = c8x_pkg::ST_OK;
                            default: begin
                                st_next = c8x_pkg::ST_NOMATCH;
                                pc_next = pc_reg;
                            end
                        endcase
                    end
                endcase
            end
        end

        // flag written after the destination so it wins on VF
        if (cmd.flag_wr) begin
            rf_we    = 1'b1;
            rf_waddr = c8x_pkg::FLAG_REG;
            rf_wdata = {7'd0, flag_reg};
        end

        if (cmd.bcd_wr) begin
            mem_we    = 1'b1;
            mem_waddr = bcd_addr[AW-1:0];
            mem_wdata = bcd_digit;
        end

        // register dump / restore, each register read and then written back
        if (cmd.x_rd) begin
            if (sts.x_oob) begin
                st_next = c8x_pkg::ST_BOUND;
            end else if (is_dump) begin
                rf_re    = 1'b1;
                rf_raddr = k_reg;
            end else begin
                mem_re = 1'b1;
            end
        end
        if (cmd.x_wr) begin
            if (is_dump) begin
                mem_we = 1'b1;
            end else begin
                rf_we    = 1'b1;
                rf_waddr = k_reg;
                rf_wdata = mem_rdata_reg;
            end
            k_next = k_reg + 4'd1;
        end

        // wrap pc into memory range
        if (cmd.fix && sts.pc_over) pc_next = pc_reg - MEM_LIM;

        // result reads
        if (cmd.wb_x) rf_re = 1'b1;
        if (cmd.wb_f) begin
            dest_next = rf_rdata_reg;
            rf_re     = 1'b1;
            rf_raddr  = c8x_pkg::FLAG_REG;
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (rf_we) rf[rf_waddr] <= rf_wdata;
        if (rf_re) rf_rdata_reg <= rf[rf_raddr];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) stk[stk_waddr] <= pc_reg[11:0];
        if (stk_re) stk_rdata_reg <= stk[stk_raddr];
    end

    // machine state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= PC_RESET;
            idx_reg <= 12'd0;
            cnt_reg <= '0;
            clr_reg <= '0;
        end else begin
            pc_reg  <= pc_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            clr_reg <= clr_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        st_reg   <= st_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        dest_reg <= dest_next;
        flag_reg <= flag_next;
        k_reg    <= k_next;
        if (cmd.latch) begin
            kind_reg <= s_kind;
            op_reg   <= s_opcode;
            rnd_reg  <= s_random_byte;
            la_reg   <= s_load_address;
            ld_reg   <= s_load_data;
        end
        if (cmd.out_load) begin
            m_program_counter <= pc_reg[11:0];
            m_index_value     <= idx_reg;
            m_flag_value      <= rf_rdata_reg;
            m_dest_value      <= dest_reg;
            m_stack_depth     <= cnt_reg;
            m_status          <= st_reg;
        end
    end

endmodule

[rtl/chip8_execute_core.sv]
// ============================================================================
// chip8_execute_core
// CHIP-8 opcode execute core with register file, stack and program memory.
// ============================================================================
// After reset the core writes the font and the default program image into
// main memory and clears V0..VF; s_ready stays low until then. Each word is
// then accepted, has its operands read (load words skip this), is executed,
// has the pc wrapped and has VX and VF read back; 8XY4/5/6/E add a flag write,
// FX33 adds one memory write per digit, and FX55/FX65 add a read and a write
// per register moved, since each register is first read from one storage
// and then written into the other. A pc that passes the end of memory has
// MEM_DEPTH subtracted once per wrap step until it is in range.
// The next word is accepted while the previous result is still waiting.
module chip8_execute_core #(
    parameter int MEM_DEPTH     = c8x_pkg::MEM_DEPTH_DEF,
    parameter int STACK_DEPTH   = c8x_pkg::STACK_DEPTH_DEF,
    parameter int START_ADDRESS = c8x_pkg::START_ADDRESS_DEF,
    localparam int CW           = $clog2(STACK_DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_kind,
    input  logic [15:0]   s_opcode,
    input  logic [7:0]    s_random_byte,
    input  logic [11:0]   s_load_address,
    input  logic [7:0]    s_load_data,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [11:0]   m_program_counter,
    output logic [11:0]   m_index_value,
    output logic [7:0]    m_flag_value,
    output logic [7:0]    m_dest_value,
    output logic [CW-1:0] m_stack_depth,
    output logic [2:0]    m_status
);

    c8x_pkg::dp_cmd_t cmd;
    c8x_pkg::dp_sts_t sts;

    // sequencer
    c8x_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    // storage and execute logic
    c8x_datapath #(
        .MEM_DEPTH     (MEM_DEPTH),
        .STACK_DEPTH   (STACK_DEPTH),
        .START_ADDRESS (START_ADDRESS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_kind            (s_kind),
        .s_opcode          (s_opcode),
        .s_random_byte     (s_random_byte),
        .s_load_address    (s_load_address),
        .s_load_data       (s_load_data),
        .m_program_counter (m_program_counter),
        .m_index_value     (m_index_value),
        .m_flag_value      (m_flag_value),
        .m_dest_value      (m_dest_value),
        .m_stack_depth     (m_stack_depth),
        .m_status          (m_status)
    );

endmodule

[rtl/c8x_checker.sv]
// ============================================================================
// c8x_checker
// Port-level checks for the CHIP-8 execute core, bound to the top level.
// ============================================================================
module c8x_checker #(
    parameter int MEM_DEPTH     = c8x_pkg::MEM_DEPTH_DEF,
    parameter int STACK_DEPTH   = c8x_pkg::STACK_DEPTH_DEF,
    localparam int CW           = $clog2(STACK_DEPTH + 1)
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input logic [11:0]   m_program_counter,
    input logic [7:0]    m_dest_value,
    input logic [CW-1:0] m_stack_depth,
    input logic [2:0]    m_status
);

    // one word in flight: ready drops right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous word still in work");

    // a waiting result word holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_program_counter)
            && $stable(m_status) && $stable(m_dest_value))
        else $error("result word changed while stalled");

    // pc always wrapped into memory
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> {1'b0, m_program_counter} < 13'(MEM_DEPTH))
        else $error("pc outside memory");

    // stack never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_stack_depth <= CW'(STACK_DEPTH))
        else $error("stack depth above limit");

    // stack full only reported when every entry is in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_status == c8x_pkg::ST_FULL)
            |-> m_stack_depth == CW'(STACK_DEPTH))
        else $error("stack full reported with room left");

endmodule

bind chip8_execute_core c8x_checker #(
    .MEM_DEPTH     (MEM_DEPTH),
    .STACK_DEPTH   (STACK_DEPTH)
) u_c8x_checker (.*);
